### hw/rtl/rhsv_pkg.sv
// shared types and constants for the rgb to hsv converter
// no dependencies; used by rhsv_div and rgb_to_hsv_8bit
`default_nettype none

package rhsv_pkg;

    // component and result width
    localparam int PIX_W = 8;

    // quotient bits resolved per divider stage, must divide PIX_W
    localparam int DIV_BITS_PER_STEP = 2;

    // hue scaling and sector bases on a 256 step circle
    localparam int HUE_STEP   = 43;
    localparam int BASE_RED   = 0;
    localparam int BASE_GREEN = 85;
    localparam int BASE_BLUE  = 171;

    // saturation full scale
    localparam int SAT_SCALE  = 255;

    // which component holds the maximum
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

endpackage

`default_nettype wire

### hw/rtl/rgb_to_hsv_8bit.sv
// top level of the pixel rgb to hsv converter
// depends on rhsv_pkg and rhsv_div
`default_nettype none

// Converts one 8-bit RGB pixel per clock, while the output is taken, into 8-bit hue,
// saturation and value. The block takes a new pixel every cycle unless the output
// stalls a full pipe. One stage finds max, min and the hue sector, one forms
// 255*(max-min) and 43*|difference|, the two dividers resolve DIV_BITS_PER_STEP
// quotient bits per stage, and a last stage applies the sector base and sign and
// registers the result. DIV_BITS_PER_STEP must divide 8.
// Each stage holds its beat only while the stage after it is full and stalled, so
// bubbles are squeezed out and s_ready drops only when every stage holds a beat and
// the output is not taken.
module rgb_to_hsv_8bit #(
    parameter int DIV_BITS_PER_STEP = rhsv_pkg::DIV_BITS_PER_STEP
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [rhsv_pkg::PIX_W-1:0] s_red,
    input  wire logic [rhsv_pkg::PIX_W-1:0] s_green,
    input  wire logic [rhsv_pkg::PIX_W-1:0] s_blue,

    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic      [rhsv_pkg::PIX_W-1:0] m_hue,
    output logic      [rhsv_pkg::PIX_W-1:0] m_saturation,
    output logic      [rhsv_pkg::PIX_W-1:0] m_value
);

    localparam int W      = rhsv_pkg::PIX_W;
    localparam int STEPS  = W / DIV_BITS_PER_STEP;
    localparam int NSTAGE = STEPS + 3;
    localparam int DIV0   = 2;
    localparam int LAST   = NSTAGE - 1;

    // stage valid bits and load enables
    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] en;

    always_comb begin
        en[LAST] = !v_reg[LAST] || m_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[LAST];

    // stage 1: max, min, sector and magnitude of the hue difference
    logic [W-1:0]       mx_next, mn_next, absdiff_next;
    logic               neg_next;
    rhsv_pkg::sector_t  sector_next;

    always_comb begin
        logic [W-1:0] hi;
        logic [W-1:0] lo;
        mx_next = s_red;
        if (s_green > mx_next) mx_next = s_green;
        if (s_blue > mx_next)  mx_next = s_blue;
        mn_next = s_red;
        if (s_green < mn_next) mn_next = s_green;
        if (s_blue < mn_next)  mn_next = s_blue;

        // red wins ties over green, green over blue
        priority if (s_red >= s_green && s_red >= s_blue) begin
            sector_next = rhsv_pkg::SECT_RED;
            hi = s_green;
            lo = s_blue;
        end else if (s_green >= s_blue) begin
            sector_next = rhsv_pkg::SECT_GREEN;
            hi = s_blue;
            lo = s_red;
        end else begin
            sector_next = rhsv_pkg::SECT_BLUE;
            hi = s_red;
            lo = s_green;
        end
        neg_next     = hi < lo;
        absdiff_next = neg_next ? (lo - hi) : (hi - lo);
    end

    logic [W-1:0]      p1_mx_reg, p1_d_reg, p1_absdiff_reg;
    logic              p1_neg_reg;
    rhsv_pkg::sector_t p1_sector_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            p1_mx_reg      <= mx_next;
            p1_d_reg       <= mx_next - mn_next;
            p1_absdiff_reg <= absdiff_next;
            p1_neg_reg     <= neg_next;
            p1_sector_reg  <= sector_next;
        end
    end

    // stage 2: scaled dividends
    logic [2*W-1:0]    p2_nsat_reg, p2_nhue_reg;
    logic [W-1:0]      p2_mx_reg, p2_d_reg;
    logic              p2_neg_reg, p2_zero_reg;
    rhsv_pkg::sector_t p2_sector_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            p2_nsat_reg   <= (2*W)'(p1_d_reg) * (2*W)'(rhsv_pkg::SAT_SCALE);
            p2_nhue_reg   <= (2*W)'(p1_absdiff_reg) * (2*W)'(rhsv_pkg::HUE_STEP);
            p2_mx_reg     <= p1_mx_reg;
            p2_d_reg      <= p1_d_reg;
            p2_neg_reg    <= p1_neg_reg;
            p2_zero_reg   <= (p1_d_reg == '0);
            p2_sector_reg <= p1_sector_reg;
        end
    end

    // dividers: saturation over max, hue step over max - min
    logic [W-1:0] sat_quo, hue_quo;

    rhsv_div #(
        .BITS_PER_STEP (DIV_BITS_PER_STEP)
    ) u_div_sat (
        .aclk (aclk),
        .en   (en[DIV0 +: STEPS]),
        .num  (p2_nsat_reg),
        .den  (p2_mx_reg),
        .quo  (sat_quo)
    );

    rhsv_div #(
        .BITS_PER_STEP (DIV_BITS_PER_STEP)
    ) u_div_hue (
        .aclk (aclk),
        .en   (en[DIV0 +: STEPS]),
        .num  (p2_nhue_reg),
        .den  (p2_d_reg),
        .quo  (hue_quo)
    );

    // side data riding alongside the divider stages
    logic [W-1:0]      sd_mx_reg     [STEPS];
    logic              sd_neg_reg    [STEPS];
    logic              sd_zero_reg   [STEPS];
    rhsv_pkg::sector_t sd_sector_reg [STEPS];

    always_ff @(posedge aclk) begin
        if (en[DIV0]) begin
            sd_mx_reg[0]     <= p2_mx_reg;
            sd_neg_reg[0]    <= p2_neg_reg;
            sd_zero_reg[0]   <= p2_zero_reg;
            sd_sector_reg[0] <= p2_sector_reg;
        end
        for (int k = 1; k < STEPS; k++) begin
            if (en[DIV0 + k]) begin
                sd_mx_reg[k]     <= sd_mx_reg[k-1];
                sd_neg_reg[k]    <= sd_neg_reg[k-1];
                sd_zero_reg[k]   <= sd_zero_reg[k-1];
                sd_sector_reg[k] <= sd_sector_reg[k-1];
            end
        end
    end

    // last stage: sector base plus signed quotient, wraps mod 256; hue and saturation are zero when max equals min
    logic [W-1:0] base;
    logic [W-1:0] hue_next, sat_next;

    always_comb begin
        unique case (sd_sector_reg[STEPS-1])
            rhsv_pkg::SECT_RED:   base = W'(rhsv_pkg::BASE_RED);
            rhsv_pkg::SECT_GREEN: base = W'(rhsv_pkg::BASE_GREEN);
            rhsv_pkg::SECT_BLUE:  base = W'(rhsv_pkg::BASE_BLUE);
            default:              base = W'(rhsv_pkg::BASE_RED);
        endcase
        if (sd_zero_reg[STEPS-1]) begin
            hue_next = '0;
            sat_next = '0;
        end else begin
            hue_next = sd_neg_reg[STEPS-1] ? (base - hue_quo) : (base + hue_quo);
            sat_next = sat_quo;
        end
    end

    logic [W-1:0] out_hue_reg, out_sat_reg, out_val_reg;

    always_ff @(posedge aclk) begin
        if (en[LAST]) begin
            out_hue_reg <= hue_next;
            out_sat_reg <= sat_next;
            out_val_reg <= sd_mx_reg[STEPS-1];
        end
    end

    assign m_hue        = out_hue_reg;
    assign m_saturation = out_sat_reg;
    assign m_value      = out_val_reg;

    // grey and black pixels carry no hue
    a_grey_no_hue : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_saturation == '0) |-> (m_hue == '0))
        else $error("hue set on a pixel with zero saturation");

    // nonzero saturation needs a nonzero maximum
    a_sat_needs_value : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_saturation != '0) |-> (m_value != '0))
        else $error("saturation set on a black pixel");

    // input backpressure only comes from a full pipe behind a stalled output
    a_ready_only_when_full : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && (v_reg == '1)))
        else $error("input stalled while the pipeline has room");

endmodule

`default_nettype wire

### hw/rtl/rhsv_div.sv
// pipelined restoring divider: 2*PIX_W bit dividend over PIX_W bit divisor
// depends on rhsv_pkg; quotient must fit in PIX_W bits (dividend high half < divisor)
`default_nettype none

module rhsv_div #(
    parameter int BITS_PER_STEP = rhsv_pkg::DIV_BITS_PER_STEP,
    localparam int W            = rhsv_pkg::PIX_W,
    localparam int STEPS        = W / BITS_PER_STEP
) (
    input  wire logic             aclk,
    input  wire logic [STEPS-1:0] en,
    input  wire logic [2*W-1:0]   num,
    input  wire logic [W-1:0]     den,
    output logic      [W-1:0]     quo
);

    logic [W-1:0] rem_reg [STEPS];
    logic [W-1:0] low_reg [STEPS];
    logic [W-1:0] quo_reg [STEPS];
    logic [W-1:0] den_reg [STEPS];

    logic [W-1:0] rem_in [STEPS];
    logic [W-1:0] low_in [STEPS];
    logic [W-1:0] quo_in [STEPS];
    logic [W-1:0] den_in [STEPS];

    logic [W-1:0] rem_next [STEPS];
    logic [W-1:0] low_next [STEPS];
    logic [W-1:0] quo_next [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        if (k == 0) begin : g_first
            assign rem_in[k] = num[2*W-1:W];
            assign low_in[k] = num[W-1:0];
            assign quo_in[k] = '0;
            assign den_in[k] = den;
        end else begin : g_rest
            assign rem_in[k] = rem_reg[k-1];
            assign low_in[k] = low_reg[k-1];
            assign quo_in[k] = quo_reg[k-1];
            assign den_in[k] = den_reg[k-1];
        end

        always_comb begin
            logic [W:0]   trial;
            logic [W-1:0] rem_v;
            logic [W-1:0] low_v;
            logic [W-1:0] quo_v;
            rem_v = rem_in[k];
            low_v = low_in[k];
            quo_v = quo_in[k];
            for (int i = 0; i < BITS_PER_STEP; i++) begin
                trial = {rem_v, low_v[W-1]};
                low_v = {low_v[W-2:0], 1'b0};
                if (trial >= {1'b0, den_in[k]}) begin
                    trial = trial - {1'b0, den_in[k]};
                    quo_v = {quo_v[W-2:0], 1'b1};
                end else begin
                    quo_v = {quo_v[W-2:0], 1'b0};
                end
                rem_v = trial[W-1:0];
            end
            rem_next[k] = rem_v;
            low_next[k] = low_v;
            quo_next[k] = quo_v;
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= den_in[k];
            end
        end
    end

    assign quo = quo_reg[STEPS-1];

endmodule

`default_nettype wire
